// ----- hw/rtl/mfd_pkg.sv -----
// Shared types, constants and helper functions of the modulated feedback delay.
`default_nettype none
package mfd_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int SET_W     = 16;
   localparam int FILT_W    = 40;
   localparam int PHASE_W   = 32;
   localparam int CH_W      = 1;
   localparam int CHANNELS  = 1 << CH_W;
   localparam int DLY_AW    = 17;
   localparam int DELAY_DEPTH = 1 << DLY_AW;
   localparam int RAM_AW    = DLY_AW + CH_W;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   localparam int SINE_AW   = 10;
   localparam int SAMPLE_RATE = 48000;

   localparam int MUL_A_W = 44;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // base delay in Q16 samples = BASE_OFS + BASE_GAIN * time_setting
   localparam longint BASE_OFS  = longint'(SAMPLE_RATE) * 6553600 / 1000;
   localparam longint BASE_GAIN = longint'(SAMPLE_RATE) * 1400 / 1000;
   localparam longint PHASE_STEP =
      (64'd17179869184 + 5 * longint'(SAMPLE_RATE) / 2) / (5 * longint'(SAMPLE_RATE));
   localparam longint MAX_DLY   = longint'(DELAY_DEPTH - 1) * 65536;
   localparam int     SWING_DIV = 125;
   // Q31 reciprocal, kept below 2^25 so it stays positive on the signed multiplier
   localparam longint RECIP_DIV = 64'd2147483648 / SWING_DIV;

   localparam int SINE_C1  = 51472;
   localparam int SINE_C2  = 21167;
   localparam int SINE_C3  = 2463;
   localparam int HP_COEF  = 131;
   localparam int LP_COEF  = 26214;
   localparam int FB_SCALE = 57672;

   localparam logic [1:0] CSR_TIME     = 2'd0;
   localparam logic [1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [1:0] CSR_DEPTH    = 2'd2;
   localparam logic [1:0] CSR_MIX      = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_BASE, ST_SINX, ST_T1, ST_T2, ST_T3, ST_MAG,
      ST_SW1, ST_SW2, ST_SW3, ST_DLY, ST_POS, ST_RDA, ST_RDB, ST_INT,
      ST_TAP, ST_HP, ST_HPU, ST_LP, ST_LPU, ST_FBG, ST_WRF, ST_WRT,
      ST_MX1, ST_MX2
   } state_type;

   typedef struct packed {
      state_type         step;
      logic              load;
      logic              fire;
      logic [RAM_AW-1:0] clr_addr;
   } cmd_type;

   function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [FILT_W+1:0] v);
      logic signed [FILT_W+1:0] hi;
      logic signed [FILT_W+1:0] lo;
      hi = (FILT_W+2)'({1'b0, {(FILT_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) return hi[FILT_W-1:0];
      else if (v < lo) return lo[FILT_W-1:0];
      else return v[FILT_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'((longint'(1) << (SAMPLE_W - 1)) - 1);
      lo = -hi - 1;
      if (v > hi) return hi[SAMPLE_W-1:0];
      else if (v < lo) return lo[SAMPLE_W-1:0];
      else return v[SAMPLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/modulated_feedback_delay_unit.sv -----
// Top level of the modulated feedback delay: sequencer plus datapath.
// Usage:
//   req_* carries one sample and its channel; a transaction completes when
//   req_valid and req_ready are both high. rsp_* returns the mixed sample and
//   the echoed channel under the same valid/ready rule. csr_* writes one of the
//   four settings (time, feedback, modulation depth, mix) and is always ready;
//   write settings only while no sample is in flight.
//   Each sample walks a fixed schedule of 24 steps around one shared multiplier
//   and one single-port delay memory (two tap reads and one write); a new
//   sample is taken only once the previous one has left its schedule. The
//   result sits in an output register: the next sample is accepted and
//   processed while it waits, and only its final step holds
//   while the receiver stalls with a result still pending.
//   Reset is synchronous; afterwards a clearing pass zeroes all 262144 words
//   of the delay memory one word a cycle, with req_ready low throughout.
`default_nettype none
module modulated_feedback_delay_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mfd_pkg::CH_W-1:0]            req_channel,
   input  wire logic signed [mfd_pkg::SAMPLE_W-1:0] req_in_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [mfd_pkg::CH_W-1:0]                 rsp_out_channel,
   output logic signed [mfd_pkg::SAMPLE_W-1:0]      rsp_out_sample,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [mfd_pkg::SET_W-1:0]           csr_data
);
   mfd_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mfd_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_channel     (req_channel),
      .req_in_sample   (req_in_sample),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_sample  (rsp_out_sample)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/mfd_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module mfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mfd_ctrl.sv -----
// Step sequencer: clearing pass, per-sample schedule and result handshake.
`default_nettype none
module mfd_ctrl (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output mfd_pkg::cmd_type cmd
);
   mfd_pkg::state_type state_ff, state_in;
   logic [mfd_pkg::RAM_AW-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic fire;

   assign fire = (state_ff == mfd_pkg::ST_MX2) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfd_pkg::ST_CLEAR: if (&clr_ff) state_in = mfd_pkg::ST_IDLE;
         mfd_pkg::ST_IDLE:  if (req_valid) state_in = mfd_pkg::ST_BASE;
         mfd_pkg::ST_BASE:  state_in = mfd_pkg::ST_SINX;
         mfd_pkg::ST_SINX:  state_in = mfd_pkg::ST_T1;
         mfd_pkg::ST_T1:    state_in = mfd_pkg::ST_T2;
         mfd_pkg::ST_T2:    state_in = mfd_pkg::ST_T3;
         mfd_pkg::ST_T3:    state_in = mfd_pkg::ST_MAG;
         mfd_pkg::ST_MAG:   state_in = mfd_pkg::ST_SW1;
         mfd_pkg::ST_SW1:   state_in = mfd_pkg::ST_SW2;
         mfd_pkg::ST_SW2:   state_in = mfd_pkg::ST_SW3;
         mfd_pkg::ST_SW3:   state_in = mfd_pkg::ST_DLY;
         mfd_pkg::ST_DLY:   state_in = mfd_pkg::ST_POS;
         mfd_pkg::ST_POS:   state_in = mfd_pkg::ST_RDA;
         mfd_pkg::ST_RDA:   state_in = mfd_pkg::ST_RDB;
         mfd_pkg::ST_RDB:   state_in = mfd_pkg::ST_INT;
         mfd_pkg::ST_INT:   state_in = mfd_pkg::ST_TAP;
         mfd_pkg::ST_TAP:   state_in = mfd_pkg::ST_HP;
         mfd_pkg::ST_HP:    state_in = mfd_pkg::ST_HPU;
         mfd_pkg::ST_HPU:   state_in = mfd_pkg::ST_LP;
         mfd_pkg::ST_LP:    state_in = mfd_pkg::ST_LPU;
         mfd_pkg::ST_LPU:   state_in = mfd_pkg::ST_FBG;
         mfd_pkg::ST_FBG:   state_in = mfd_pkg::ST_WRF;
         mfd_pkg::ST_WRF:   state_in = mfd_pkg::ST_WRT;
         mfd_pkg::ST_WRT:   state_in = mfd_pkg::ST_MX1;
         mfd_pkg::ST_MX1:   state_in = mfd_pkg::ST_MX2;
         mfd_pkg::ST_MX2:   if (fire) state_in = mfd_pkg::ST_IDLE;
         default:           state_in = mfd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == mfd_pkg::ST_IDLE);
      rsp_valid    = rsp_valid_ff;
      clr_in       = (state_ff == mfd_pkg::ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
      cmd.step     = state_ff;
      cmd.load     = (state_ff == mfd_pkg::ST_IDLE) && req_valid;
      cmd.fire     = fire;
      cmd.clr_addr = clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mfd_datapath.sv -----
// Datapath: settings, channel state, shared multiplier, delay store and result register.
`default_nettype none
module mfd_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mfd_pkg::cmd_type                  cmd,
   input  wire logic [mfd_pkg::CH_W-1:0]          req_channel,
   input  wire logic signed [mfd_pkg::SAMPLE_W-1:0] req_in_sample,
   input  wire logic                              csr_valid,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [mfd_pkg::SET_W-1:0]         csr_data,
   output logic [mfd_pkg::CH_W-1:0]               rsp_out_channel,
   output logic signed [mfd_pkg::SAMPLE_W-1:0]    rsp_out_sample
);
   localparam int SW = mfd_pkg::SAMPLE_W;
   localparam int FW = mfd_pkg::FILT_W;
   localparam int AW = mfd_pkg::MUL_A_W;
   localparam int BW = mfd_pkg::MUL_B_W;
   localparam int PW = mfd_pkg::MUL_P_W;
   localparam int DW = mfd_pkg::DLY_AW;
   localparam int LOWZ = mfd_pkg::PHASE_W - mfd_pkg::SINE_AW;

   logic [mfd_pkg::SET_W-1:0] time_ff, fb_ff, depth_ff, mix_ff;

   logic [DW-1:0]                 wix_ff [mfd_pkg::CHANNELS];
   logic [mfd_pkg::PHASE_W-1:0]   phs_ff [mfd_pkg::CHANNELS];
   logic signed [FW-1:0]          hpm_ff [mfd_pkg::CHANNELS];
   logic signed [FW-1:0]          lpm_ff [mfd_pkg::CHANNELS];

   logic [mfd_pkg::CH_W-1:0]   chan_ff;
   logic signed [SW-1:0]       x_ff;
   logic [mfd_pkg::PHASE_W-1:0] ph_ff;
   logic [DW-1:0]              widx_ff;
   logic signed [FW-1:0]       hp_ff, hp_in, lp_ff, lp_in;
   logic signed [PW-1:0]       p_ff, prod;
   logic [33:0]                base_ff, dly_ff;
   logic [16:0]                xs_ff, x2_ff;
   logic                       sneg_ff;
   logic [32:0]                q_ff;
   logic [25:0]                swing_ff, est;
   logic [DW-1:0]              idx_ff;
   logic [15:0]                frac_ff;
   logic signed [SW-1:0]       ta_ff, tap_ff;
   logic signed [63:0]         acc_ff;
   logic [mfd_pkg::CH_W-1:0]   och_ff;
   logic signed [SW-1:0]       osmp_ff;

   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic                 mul_en;

   logic [29:0] u_raw;
   logic [30:0] u_fold;
   logic [16:0] xs_w, pq15;
   logic [33:0] rem;
   logic signed [34:0] dsum;
   logic [DW+15:0] rpos;
   logic signed [SW:0] tdiff;
   logic signed [FW:0] hdiff;
   logic signed [FW+1:0] ldiff, hsum, lsum;
   logic signed [63:0] mixed;
   logic [mfd_pkg::RAM_AW-1:0] ram_addr;
   logic ram_we;
   logic [SW-1:0] ram_wdata, ram_rdata;

   // quarter-wave fold of the table angle; in the mirrored quarters the fold of zero is a full quarter
   assign u_raw  = {ph_ff[29:LOWZ], {LOWZ{1'b0}}};
   assign u_fold = ph_ff[30] ? 31'h40000000 - {1'b0, u_raw} : {1'b0, u_raw};
   assign xs_w   = {1'b0, u_fold[30:15]};
   assign pq15   = p_ff[31:15];

   assign est  = p_ff[56:31];
   assign rem  = {1'b0, q_ff} - 34'(est) * 34'(mfd_pkg::SWING_DIV);
   assign dsum = sneg_ff ? $signed({1'b0, base_ff}) - $signed({9'b0, swing_ff})
                         : $signed({1'b0, base_ff}) + $signed({9'b0, swing_ff});
   assign rpos = {widx_ff, 16'b0} - dly_ff[DW+15:0];

   assign tdiff = $signed(ram_rdata) - ta_ff;
   assign hdiff = (FW+1)'($signed({tap_ff, 15'b0})) - hp_ff;
   assign ldiff = (FW+2)'(hdiff) - lp_ff;
   assign hsum  = (FW+2)'(hp_ff) + (FW+2)'(p_ff >>> 16);
   assign lsum  = (FW+2)'(lp_ff) + (FW+2)'(p_ff >>> 16);
   assign mixed = acc_ff + 64'(p_ff);

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.step)
         mfd_pkg::ST_BASE: begin
            mul_a = AW'($signed({1'b0, time_ff}));
            mul_b = BW'(mfd_pkg::BASE_GAIN);
         end
         mfd_pkg::ST_SINX: begin
            mul_a = AW'($signed({1'b0, xs_w}));
            mul_b = BW'($signed({1'b0, xs_w}));
         end
         mfd_pkg::ST_T1: begin
            mul_a = AW'($signed({1'b0, pq15}));
            mul_b = BW'(mfd_pkg::SINE_C3);
         end
         mfd_pkg::ST_T2: begin
            mul_a = AW'($signed({1'b0, 17'(mfd_pkg::SINE_C2) - pq15}));
            mul_b = BW'($signed({1'b0, x2_ff}));
         end
         mfd_pkg::ST_T3: begin
            mul_a = AW'($signed({1'b0, xs_ff}));
            mul_b = BW'($signed({1'b0, 17'(mfd_pkg::SINE_C1) - pq15}));
         end
         mfd_pkg::ST_MAG: begin
            mul_a = AW'($signed({1'b0, depth_ff}));
            mul_b = BW'($signed({1'b0, pq15}));
         end
         mfd_pkg::ST_SW1: begin
            mul_a = AW'($signed({1'b0, p_ff[30:0]}));
            mul_b = BW'($signed({1'b0, base_ff[32:8]}));
         end
         mfd_pkg::ST_SW2: begin
            mul_a = AW'($signed({1'b0, p_ff[55:23]}));
            mul_b = BW'(mfd_pkg::RECIP_DIV);
         end
         mfd_pkg::ST_INT: begin
            mul_a = AW'(tdiff);
            mul_b = BW'($signed({1'b0, frac_ff}));
         end
         mfd_pkg::ST_HP: begin
            mul_a = AW'(hdiff);
            mul_b = BW'(mfd_pkg::HP_COEF);
         end
         mfd_pkg::ST_LP: begin
            mul_a = AW'(ldiff);
            mul_b = BW'(mfd_pkg::LP_COEF);
         end
         mfd_pkg::ST_FBG: begin
            mul_a = AW'($signed({1'b0, fb_ff}));
            mul_b = BW'(mfd_pkg::FB_SCALE);
         end
         mfd_pkg::ST_WRF: begin
            mul_a = AW'(lp_ff);
            mul_b = BW'($signed({1'b0, p_ff[31:16]}));
         end
         mfd_pkg::ST_WRT: begin
            mul_a = AW'(x_ff);
            mul_b = BW'($signed(18'h10000 - {2'b0, mix_ff}));
         end
         mfd_pkg::ST_MX1: begin
            mul_a = AW'(lp_ff);
            mul_b = BW'($signed({1'b0, mix_ff}));
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      hp_in = hp_ff;
      lp_in = lp_ff;
      if (cmd.load) begin
         hp_in = hpm_ff[req_channel];
         lp_in = lpm_ff[req_channel];
      end else if (cmd.step == mfd_pkg::ST_HPU) begin
         hp_in = mfd_pkg::sat_filt(hsum);
      end else if (cmd.step == mfd_pkg::ST_LPU) begin
         lp_in = mfd_pkg::sat_filt(lsum);
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = '0;
      case (cmd.step)
         mfd_pkg::ST_CLEAR: begin
            ram_addr = cmd.clr_addr;
            ram_we   = 1'b1;
         end
         mfd_pkg::ST_RDB: ram_addr = {chan_ff, DW'(idx_ff + 1'b1)};
         mfd_pkg::ST_WRT: begin
            ram_addr  = {chan_ff, widx_ff};
            ram_we    = 1'b1;
            ram_wdata = mfd_pkg::sat_smp(64'(x_ff) + 64'(p_ff >>> 31));
         end
         default: ram_addr = {chan_ff, idx_ff};
      endcase
   end

   mfd_ram #(.WIDTH(SW), .DEPTH(mfd_pkg::RAM_DEPTH)) u_line (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // settings and per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= 16'h8000;
         fb_ff    <= '0;
         depth_ff <= '0;
         mix_ff   <= '0;
         for (int i = 0; i < mfd_pkg::CHANNELS; i++) begin
            wix_ff[i] <= '0;
            phs_ff[i] <= '0;
            hpm_ff[i] <= '0;
            lpm_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               mfd_pkg::CSR_TIME:     time_ff  <= csr_data;
               mfd_pkg::CSR_FEEDBACK: fb_ff    <= csr_data;
               mfd_pkg::CSR_DEPTH:    depth_ff <= csr_data;
               mfd_pkg::CSR_MIX:      mix_ff   <= csr_data;
               default: ;
            endcase
         end
         if (cmd.fire) begin
            wix_ff[chan_ff] <= widx_ff + 1'b1;
            phs_ff[chan_ff] <= ph_ff + mfd_pkg::PHASE_W'(mfd_pkg::PHASE_STEP);
            hpm_ff[chan_ff] <= hp_ff;
            lpm_ff[chan_ff] <= lp_ff;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      hp_ff <= hp_in;
      lp_ff <= lp_in;
      if (mul_en) p_ff <= prod;
      if (cmd.load) begin
         chan_ff <= req_channel;
         x_ff    <= req_in_sample;
         ph_ff   <= phs_ff[req_channel];
         widx_ff <= wix_ff[req_channel];
      end
      case (cmd.step)
         mfd_pkg::ST_SINX: begin
            base_ff <= 34'(p_ff) + 34'(mfd_pkg::BASE_OFS);
            xs_ff   <= xs_w;
            sneg_ff <= ph_ff[31];
         end
         mfd_pkg::ST_T1:  x2_ff <= pq15;
         mfd_pkg::ST_SW2: q_ff  <= p_ff[55:23];
         mfd_pkg::ST_SW3: swing_ff <= est + 26'(rem >= 34'(mfd_pkg::SWING_DIV));
         mfd_pkg::ST_DLY: begin
            if (dsum < 0) dly_ff <= '0;
            else if (dsum > 35'(mfd_pkg::MAX_DLY)) dly_ff <= 34'(mfd_pkg::MAX_DLY);
            else dly_ff <= dsum[33:0];
         end
         mfd_pkg::ST_POS: begin
            idx_ff  <= rpos[DW+15:16];
            frac_ff <= rpos[15:0];
         end
         mfd_pkg::ST_RDB: ta_ff  <= $signed(ram_rdata);
         mfd_pkg::ST_TAP: tap_ff <= SW'(ta_ff + SW'(p_ff >>> 16));
         mfd_pkg::ST_MX1: acc_ff <= 64'(p_ff) <<< 15;
         default: ;
      endcase
      if (cmd.fire) begin
         och_ff  <= chan_ff;
         osmp_ff <= mfd_pkg::sat_smp(mixed >>> 31);
      end
   end

   assign rsp_out_channel = och_ff;
   assign rsp_out_sample  = osmp_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/mfd_checker.sv -----
// Port-level assertions for the modulated feedback delay, bound to the top level.
`default_nettype none
module mfd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [mfd_pkg::CH_W-1:0]            req_channel,
   input wire logic signed [mfd_pkg::SAMPLE_W-1:0] req_in_sample,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [mfd_pkg::CH_W-1:0]            rsp_out_channel,
   input wire logic signed [mfd_pkg::SAMPLE_W-1:0] rsp_out_sample,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic [1:0]                          csr_index,
   input wire logic [mfd_pkg::SET_W-1:0]           csr_data
);
   // reset starts the clearing pass: nothing accepted, nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // one sample in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample)
         && $stable(rsp_out_channel))
      else $error("result changed while stalled");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_channel)
         && $stable(req_in_sample))
      else $error("request changed while waiting");

   // settings change only with the block idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_ready && !rsp_valid
         && !$isunknown({csr_index, csr_data}))
      else $error("settings written while a sample is in flight");
endmodule

bind modulated_feedback_delay_unit mfd_checker u_checker (.*);
`default_nettype wire
